>>> sv/hhi_pkg.sv
// Package for the hopscotch hash index: action and outcome codes, beat structs.
// No dependencies.
package hhi_pkg;

    localparam logic [2:0] ACT_GET_START  = 3'd0;
    localparam logic [2:0] ACT_GET_RESUME = 3'd1;
    localparam logic [2:0] ACT_SET_START  = 3'd2;
    localparam logic [2:0] ACT_SET_RESUME = 3'd3;
    localparam logic [2:0] ACT_SET_MATCH  = 3'd4;

    localparam logic [1:0] OUT_CANDIDATE = 2'd0;
    localparam logic [1:0] OUT_NOT_FOUND = 2'd1;
    localparam logic [1:0] OUT_WRITTEN   = 2'd2;
    localparam logic [1:0] OUT_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [17:0] key_hash;
        logic [4:0]  resume_offset;
        logic [47:0] new_location;
        logic [15:0] entry_size;
    } req_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [4:0]  slot_offset;
        logic [47:0] location;
        logic [15:0] stored_size;
    } rsp_t;

    // Datapath address and data selects.
    localparam logic [1:0] ADR_PROBE  = 2'd0;
    localparam logic [1:0] ADR_VICTIM = 2'd1;
    localparam logic [1:0] ADR_DEST   = 2'd2;

    typedef struct packed {
        logic       load_req;
        logic [1:0] rd_sel;
        logic       rd_en;
        logic       set_off;
        logic [6:0] off_val;
        logic       set_d;
        logic       d_from_hop;
        logic       inc_d;
        logic       latch_victim;
        logic       mv_write;
        logic       new_write;
        logic       clr_step;
        logic       clr_write;
        logic       rsp_load;
        logic [1:0] rsp_code;
    } cmd_t;

    typedef struct packed {
        logic       rd_valid;
        logic       rd_tag_eq;
        logic [6:0] off;
        logic [6:0] d;
        logic       clr_done;
    } sts_t;

endpackage

>>> sv/hopscotch_hash_index.sv
// Hopscotch hash index top level: joins controller and datapath.
// Depends on hhi_pkg, hhi_ctrl, hhi_datapath.
//
// One item at a time. After reset a sweep over all 2^(IDX_BITS+DIR_BITS) slots (4096)
// marks every slot invalid before the first item is taken. A get reads the probed
// slots in turn, up to HOP_RANGE of them; a set that must displace adds a free-slot
// walk and a backward victim search, all bounded by the single read port of the
// slot memory, one read per cycle.
module hopscotch_hash_index
    import hhi_pkg::*;
#(
    parameter int IDX_BITS      = 10,
    parameter int DIR_BITS      = 2,
    parameter int HOP_RANGE     = 32,
    parameter int LOCATION_BITS = 48
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);
    cmd_t cmd;
    sts_t sts;

    hhi_ctrl #(.HOP_RANGE(HOP_RANGE)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .req_valid(in_valid), .req_ready(in_ready), .req(in_data),
        .rsp_valid(out_valid), .rsp_ready(out_ready),
        .sts(sts), .cmd(cmd)
    );

    hhi_datapath #(
        .IDX_BITS(IDX_BITS), .DIR_BITS(DIR_BITS),
        .LOCATION_BITS(LOCATION_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .req(in_data),
        .cmd(cmd), .sts(sts), .rsp(out_data)
    );
endmodule

>>> sv/hhi_datapath.sv
// Datapath for the hopscotch hash index: slot memory, offset counters, result register.
// Depends on hhi_pkg.
module hhi_datapath
    import hhi_pkg::*;
#(
    parameter int IDX_BITS      = 10,
    parameter int DIR_BITS      = 2,
    parameter int LOCATION_BITS = 48
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output rsp_t rsp
);
    localparam int ABITS = IDX_BITS + DIR_BITS;
    localparam int WBITS = 5 + 8 + 16 + LOCATION_BITS;
    localparam logic [LOCATION_BITS-1:0] LOC_INV = '1;

    logic [WBITS-1:0] mem [2**ABITS];
    logic [WBITS-1:0] rd_reg;
    logic [ABITS-1:0] clr_reg;

    logic [IDX_BITS-1:0] home_reg, origin_reg;
    logic [7:0] tag_reg;
    logic [6:0] off_reg, d_reg;
    logic [47:0] nloc_reg;
    logic [15:0] nsize_reg;
    logic [WBITS-1:0] vic_reg;
    rsp_t rsp_reg;

    logic [DIR_BITS:0] dir_w;
    logic [ABITS-1:0] rd_addr, wr_addr;
    logic [IDX_BITS-1:0] slot_lo;
    logic [WBITS-1:0] wr_data;
    logic wr_en;
    logic [LOCATION_BITS-1:0] rd_loc;
    logic [4:0] rd_hop;
    logic [7:0] rd_tag;
    logic [15:0] rd_size;

    assign rd_loc  = rd_reg[LOCATION_BITS-1:0];
    assign rd_size = rd_reg[LOCATION_BITS+15:LOCATION_BITS];
    assign rd_tag  = rd_reg[LOCATION_BITS+23:LOCATION_BITS+16];
    assign rd_hop  = rd_reg[WBITS-1:WBITS-5];
    assign dir_w   = (DIR_BITS+1)'(tag_reg);

    // Form addresses: table select on top, wrapped slot index below.
    always_comb
    begin
        slot_lo = home_reg + IDX_BITS'(off_reg);
        unique case (cmd.rd_sel)
            ADR_VICTIM: slot_lo = home_reg + IDX_BITS'(off_reg);
            ADR_DEST:   slot_lo = origin_reg + IDX_BITS'(d_reg);
            default:    slot_lo = home_reg + IDX_BITS'(off_reg);
        endcase
        rd_addr = ABITS'({dir_w, slot_lo});
        wr_addr = rd_addr;
        wr_data = {vic_reg[WBITS-1:WBITS-5], vic_reg[WBITS-6:0]};
        wr_en   = 1'b0;
        if (cmd.clr_write)
        begin
            wr_addr = clr_reg;
            wr_data = {5'd0, 8'd0, 16'd0, LOC_INV};
            wr_en   = 1'b1;
        end
        else if (cmd.mv_write)
        begin
            wr_data = {d_reg[4:0], vic_reg[WBITS-6:0]};
            wr_en   = 1'b1;
        end
        else if (cmd.new_write)
        begin
            wr_data = {off_reg[4:0], tag_reg, nsize_reg, nloc_reg[LOCATION_BITS-1:0]};
            wr_en   = 1'b1;
        end
    end

    // Slot memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_reg <= mem[rd_addr];
    end

    // Hold request fields and walk counters.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            home_reg  <= req.key_hash[IDX_BITS-1:0];
            tag_reg   <= req.key_hash[IDX_BITS+7:IDX_BITS];
            nloc_reg  <= req.new_location;
            nsize_reg <= req.entry_size;
        end
        if (cmd.set_off)
            off_reg <= cmd.off_val;
        if (cmd.latch_victim)
        begin
            vic_reg    <= rd_reg;
            origin_reg <= home_reg + IDX_BITS'(off_reg) - IDX_BITS'(rd_hop);
        end
        if (cmd.set_d)
            d_reg <= cmd.d_from_hop ? 7'(rd_hop) + 7'd1 : 7'd0;
        else if (cmd.inc_d)
            d_reg <= d_reg + 7'd1;
    end

    // Sweep the memory to invalid after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_step)
            clr_reg <= clr_reg + 1'b1;
    end

    // Load the result beat.
    always_ff @(posedge clk)
    begin
        if (cmd.rsp_load)
        begin
            rsp_reg.outcome <= cmd.rsp_code;
            unique case (cmd.rsp_code)
                OUT_CANDIDATE:
                begin
                    rsp_reg.slot_offset <= off_reg[4:0];
                    rsp_reg.location    <= 48'(rd_loc);
                    rsp_reg.stored_size <= rd_size;
                end
                OUT_WRITTEN:
                begin
                    rsp_reg.slot_offset <= off_reg[4:0];
                    rsp_reg.location    <= 48'(nloc_reg[LOCATION_BITS-1:0]);
                    rsp_reg.stored_size <= nsize_reg;
                end
                default:
                begin
                    rsp_reg.slot_offset <= '0;
                    rsp_reg.location    <= '0;
                    rsp_reg.stored_size <= '0;
                end
            endcase
        end
    end

    assign rsp = rsp_reg;
    assign sts = '{rd_valid:  (rd_loc != LOC_INV),
                   rd_tag_eq: (rd_tag == tag_reg),
                   off:       off_reg,
                   d:         d_reg,
                   clr_done:  (clr_reg == '1)};
endmodule

>>> sv/hhi_ctrl.sv
// Controller for the hopscotch hash index: sequences probe, free search, displacement.
// Depends on hhi_pkg.
module hhi_ctrl
    import hhi_pkg::*;
#(
    parameter int HOP_RANGE = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PRD   = 4'd2;
    localparam logic [3:0] S_PCHK  = 4'd3;
    localparam logic [3:0] S_FRD   = 4'd4;
    localparam logic [3:0] S_FCHK  = 4'd5;
    localparam logic [3:0] S_VRD   = 4'd6;
    localparam logic [3:0] S_VCHK  = 4'd7;
    localparam logic [3:0] S_DRD   = 4'd8;
    localparam logic [3:0] S_DCHK  = 4'd9;
    localparam logic [3:0] S_WRITE = 4'd10;
    localparam logic [3:0] S_RSP   = 4'd11;

    localparam logic [6:0] HR  = 7'(HOP_RANGE);
    localparam logic [6:0] HRM = 7'(HOP_RANGE - 1);

    logic [3:0] state_reg, state_next;
    logic [2:0] act_reg, act_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       accept;
    logic [6:0] from;

    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign from = (req.action == ACT_GET_RESUME || req.action == ACT_SET_RESUME)
                  ? 7'(req.resume_offset) + 7'd1 : 7'd0;

    // Next state and datapath commands.
    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        act_next = act_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_write = 1'b1;
                cmd.clr_step  = 1'b1;
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_req = 1'b1;
                    act_next = req.action;
                    cmd.set_off = 1'b1;
                    if (req.action == ACT_SET_MATCH)
                    begin
                        cmd.off_val = 7'(req.resume_offset);
                        state_next = S_WRITE;
                    end
                    else if (req.action > ACT_SET_MATCH)
                        state_next = S_RSP;
                    else
                    begin
                        cmd.off_val = from;
                        state_next = S_PRD;
                    end
                end
            end
            S_PRD:
            begin
                if (sts.off >= HR)
                begin
                    cmd.set_off = 1'b1;
                    if (act_reg >= ACT_SET_START)
                        state_next = S_FRD;
                    else
                        state_next = S_RSP;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                if (sts.rd_valid && sts.rd_tag_eq)
                begin
                    cmd.rsp_load = 1'b1;
                    cmd.rsp_code = OUT_CANDIDATE;
                    rsp_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.set_off = 1'b1;
                    cmd.off_val = sts.off + 7'd1;
                    state_next = S_PRD;
                end
            end
            S_FRD:
            begin
                if (sts.off >= HR)
                begin
                    cmd.set_off = 1'b1;
                    cmd.off_val = HRM;
                    state_next = S_VRD;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (!sts.rd_valid)
                    state_next = S_WRITE;
                else
                begin
                    cmd.set_off = 1'b1;
                    cmd.off_val = sts.off + 7'd1;
                    state_next = S_FRD;
                end
            end
            S_VRD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ADR_VICTIM;
                state_next = S_VCHK;
            end
            S_VCHK:
            begin
                cmd.latch_victim = 1'b1;
                cmd.set_d = 1'b1;
                cmd.d_from_hop = 1'b1;
                state_next = S_DRD;
            end
            S_DRD:
            begin
                if (sts.d >= HR)
                begin
                    if (sts.off == 7'd0)
                    begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_code = OUT_FULL;
                        rsp_valid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.set_off = 1'b1;
                        cmd.off_val = sts.off - 7'd1;
                        state_next = S_VRD;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ADR_DEST;
                    state_next = S_DCHK;
                end
            end
            S_DCHK:
            begin
                cmd.rd_sel = ADR_DEST;
                if (!sts.rd_valid)
                begin
                    cmd.mv_write = 1'b1;
                    state_next = S_WRITE;
                end
                else
                begin
                    cmd.inc_d = 1'b1;
                    state_next = S_DRD;
                end
            end
            S_WRITE:
            begin
                cmd.new_write = 1'b1;
                cmd.rsp_load  = 1'b1;
                cmd.rsp_code  = OUT_WRITTEN;
                rsp_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            S_RSP:
            begin
                cmd.rsp_load = 1'b1;
                cmd.rsp_code = OUT_NOT_FOUND;
                rsp_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            act_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> !req_ready)
        else $error("item accepted during clear sweep");
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.clr_write, cmd.mv_write, cmd.new_write}) <= 1)
        else $error("two memory writes at once");
    a_rsp_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rsp_load |=> rsp_valid)
        else $error("result loaded but not shown");
`endif
endmodule

>>> dv/tb_hopscotch_hash_index.sv
// Testbench for hopscotch_hash_index: random and directed get/set beats, checked
// against a slot-table predictor held in a small scoreboard class. Depends on hhi_pkg.
`timescale 1ns / 100ps

module tb_hopscotch_hash_index;
    import hhi_pkg::*;

    localparam logic [2:0] ACT_BAD_LO = 3'd5;
    localparam int NUM_SLOTS = 4096;
    localparam int HOP = 32;
    localparam int ITEMS = 700;

    class slot_table_scoreboard;
        logic [47:0] loc_mem [NUM_SLOTS];
        logic [7:0]  tag_mem [NUM_SLOTS];
        logic [15:0] size_mem [NUM_SLOTS];
        logic [4:0]  hop_mem [NUM_SLOTS];
        rsp_t        expected_rsp [$];
        rsp_t        last_rsp;
        int          errors;

        function void clear();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                loc_mem[i] = '1;
                tag_mem[i] = '0;
                size_mem[i] = '0;
                hop_mem[i] = '0;
            end
            errors = 0;
        endfunction

        function int slot_of(logic [1:0] dir, int home, int off);
            return int'({dir, 10'((home + off) & 1023)});
        endfunction

        function bit is_free(int s);
            return loc_mem[s] == '1;
        endfunction

        // Find a free slot in the neighborhood, or displace one neighbor entry.
        function int make_room(logic [1:0] dir, int home);
            int cur;
            int origin;
            int t;
            for (int off = 0; off < HOP; off++)
                if (is_free(slot_of(dir, home, off)))
                    return off;
            for (int off = HOP - 1; off >= 0; off--)
            begin
                cur = slot_of(dir, home, off);
                origin = (((home + off) & 1023) - int'(hop_mem[cur])) & 1023;
                for (int d = int'(hop_mem[cur]) + 1; d < HOP; d++)
                begin
                    t = slot_of(dir, origin, d);
                    if (is_free(t))
                    begin
                        hop_mem[t] = 5'(d);
                        tag_mem[t] = tag_mem[cur];
                        size_mem[t] = size_mem[cur];
                        loc_mem[t] = loc_mem[cur];
                        return off;
                    end
                end
            end
            return -1;
        endfunction

        // Work out the result of one accepted request beat and update the table.
        function rsp_t predict_lookup(req_t r);
            rsp_t        rsp;
            int          home;
            logic [7:0]  tag;
            logic [1:0]  dir;
            int          off;
            int          from;
            int          s;
            bit          do_write;
            home = int'(r.key_hash[9:0]);
            tag = r.key_hash[17:10];
            dir = tag[1:0];
            off = -1;
            do_write = 0;
            rsp = '0;
            rsp.outcome = OUT_NOT_FOUND;
            if (r.action <= ACT_SET_RESUME)
            begin
                from = (r.action == ACT_GET_RESUME || r.action == ACT_SET_RESUME)
                       ? int'(r.resume_offset) + 1 : 0;
                for (int o = from; o < HOP && off < 0; o++)
                begin
                    s = slot_of(dir, home, o);
                    if (!is_free(s) && tag_mem[s] == tag)
                        off = o;
                end
                if (off >= 0)
                begin
                    s = slot_of(dir, home, off);
                    rsp.outcome = OUT_CANDIDATE;
                    rsp.slot_offset = 5'(off);
                    rsp.location = loc_mem[s];
                    rsp.stored_size = size_mem[s];
                    return rsp;
                end
                if (r.action >= ACT_SET_START)
                begin
                    off = make_room(dir, home);
                    if (off < 0)
                    begin
                        rsp.outcome = OUT_FULL;
                        return rsp;
                    end
                    do_write = 1;
                end
            end
            else if (r.action == ACT_SET_MATCH)
            begin
                off = int'(r.resume_offset);
                do_write = 1;
            end
            if (do_write)
            begin
                s = slot_of(dir, home, off);
                hop_mem[s] = 5'(off);
                tag_mem[s] = tag;
                size_mem[s] = r.entry_size;
                loc_mem[s] = r.new_location;
                rsp.outcome = OUT_WRITTEN;
                rsp.slot_offset = 5'(off);
                rsp.location = loc_mem[s];
                rsp.stored_size = r.entry_size;
            end
            return rsp;
        endfunction

        function void note_request(req_t r);
            last_rsp = predict_lookup(r);
            expected_rsp.push_back(last_rsp);
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp;
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected result beat exp none got %h", $time, got);
                errors++;
                return;
            end
            exp = expected_rsp.pop_front();
            if (got.outcome !== exp.outcome)
                $display("%0t: outcome exp %0d got %0d", $time, exp.outcome, got.outcome);
            if (got.slot_offset !== exp.slot_offset)
                $display("%0t: slot_offset exp %0d got %0d", $time,
                         exp.slot_offset, got.slot_offset);
            if (got.location !== exp.location)
                $display("%0t: location exp %h got %h", $time, exp.location, got.location);
            if (got.stored_size !== exp.stored_size)
                $display("%0t: stored_size exp %h got %h", $time,
                         exp.stored_size, got.stored_size);
            if (got !== exp)
                errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_data;
    logic out_valid;
    logic out_ready;
    rsp_t out_data;

    slot_table_scoreboard sb;
    int sent_count;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_taken;

    hopscotch_hash_index dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Pick idle rates from progress: receiver-heavy, sender-heavy, then none.
    always_comb
    begin
        if (sent_count < ITEMS / 3)
        begin
            tx_idle_pct = 30;
            rx_idle_pct = 49;
        end
        else if (sent_count < 2 * ITEMS / 3)
        begin
            tx_idle_pct = 49;
            rx_idle_pct = 30;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    // Drive one request beat, holding valid until accepted.
    task automatic send_request(input req_t r);
        @(negedge clk);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do @(posedge clk); while (!in_ready);
        sb.note_request(r);
        sent_count++;
    endtask

    function automatic req_t make_req(logic [2:0] act, logic [17:0] h, logic [4:0] res);
        req_t r;
        r.action = act;
        r.key_hash = h;
        r.resume_offset = res;
        r.new_location = 48'({$urandom(), $urandom()});
        r.entry_size = 16'($urandom());
        return r;
    endfunction

    // Hash from a crowded window so neighborhoods collide, fill and overflow.
    function automatic logic [17:0] crowded_hash(int region);
        logic [7:0] tag;
        if ($urandom_range(0, 1))
            tag = 8'($urandom_range(0, 3) * 4 + region % 4);
        else
            tag = 8'($urandom());
        tag[1:0] = 2'(region);
        return {tag, 10'((region * 200 + $urandom_range(0, 7)) & 1023)};
    endfunction

    // Receiver: random stall, plus one long hold-off that also holds back the sender.
    always @(negedge clk)
    begin
        if (!hold_taken && sent_count >= 300)
        begin
            hold_taken = 1;
            out_ready <= 1'b0;
            repeat (400) @(negedge clk);
        end
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    initial
    begin
        #60_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        req_t r;
        logic [17:0] h;
        int region;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        sent_count = 0;
        hold_taken = 0;
        sb = new();
        sb.clear();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: miss, write, hit, resume, past-range resume, match at far offset.
        h = 18'h3FFFF;
        send_request(make_req(ACT_GET_START, h, 5'd0));
        r = make_req(ACT_SET_START, h, 5'd0);
        r.new_location = '0;
        r.entry_size = 16'hFFFF;
        send_request(r);
        send_request(make_req(ACT_GET_START, h, 5'd0));
        send_request(make_req(ACT_GET_RESUME, h, 5'd0));
        send_request(make_req(ACT_SET_RESUME, h, 5'd0));
        send_request(make_req(ACT_GET_RESUME, h, 5'd31));
        r = make_req(ACT_SET_MATCH, h, 5'd31);
        r.new_location = 48'hFFFF_FFFF_FFFE;
        send_request(r);
        send_request(make_req(ACT_GET_START, h, 5'd0));
        send_request(make_req(ACT_GET_RESUME, h, 5'd1));
        // Writing an all-ones location leaves the slot invalid, so the probe skips it.
        r = make_req(ACT_SET_MATCH, 18'h00000, 5'd0);
        r.new_location = '1;
        r.entry_size = '0;
        send_request(r);
        send_request(make_req(ACT_GET_START, 18'h00000, 5'd0));
        send_request(make_req(ACT_SET_START, 18'h00000, 5'd0));
        for (int a = 0; a < 3; a++)
            send_request(make_req(ACT_BAD_LO + 3'(a), 18'($urandom()), 5'($urandom())));
        send_request(make_req(ACT_SET_MATCH, 18'h003FF, 5'd5));
        send_request(make_req(ACT_GET_START, 18'h003FF, 5'd0));

        // Random: well-formed get/set sequences, some noise and broken resumes.
        while (sent_count < ITEMS)
        begin
            region = $urandom_range(0, 3);
            h = ($urandom_range(0, 99) < 80) ? crowded_hash(region) : 18'($urandom());
            case ($urandom_range(0, 9))
                0:
                    send_request(make_req(3'($urandom()), 18'($urandom()), 5'($urandom())));
                1, 2, 3:
                begin
                    send_request(make_req(ACT_GET_START, h, 5'd0));
                    while (sb.last_rsp.outcome == OUT_CANDIDATE && $urandom_range(0, 3) != 0)
                        send_request(make_req(ACT_GET_RESUME, h, sb.last_rsp.slot_offset));
                end
                default:
                begin
                    send_request(make_req(ACT_SET_START, h, 5'd0));
                    while (sb.last_rsp.outcome == OUT_CANDIDATE)
                    begin
                        if ($urandom_range(0, 1))
                            send_request(make_req(ACT_SET_MATCH, h, sb.last_rsp.slot_offset));
                        else
                            send_request(make_req(ACT_SET_RESUME, h, sb.last_rsp.slot_offset));
                    end
                end
            endcase
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain, then allow the block's worst case to pass.
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
        if (sb.errors == 0 && sb.expected_rsp.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
sv/hhi_pkg.sv
sv/hhi_datapath.sv
sv/hhi_ctrl.sv
sv/hopscotch_hash_index.sv
dv/tb_hopscotch_hash_index.sv
